FILE: hw/rtl/top_k_score_table_defines.svh
// Assertion macros for the top-k score table; empty bodies when SYNTH is defined.
`ifndef TOP_K_SCORE_TABLE_DEFINES_SVH
`define TOP_K_SCORE_TABLE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication: whenever ante holds, cons must hold on that edge.
`define TKS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication: whenever ante holds, cons must hold on the following edge.
`define TKS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TKS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TKS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/tks_pkg.sv
// Shared payload and table entry types for the top-k score table.
package tks_pkg;

	typedef struct packed {
		logic signed [31:0] new_score;
		logic [4:0]         play_day;
		logic [3:0]         play_month;
		logic [11:0]        play_year;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         rank;
		logic signed [31:0] entry_score;
		logic [4:0]         entry_day;
		logic [3:0]         entry_month;
		logic [11:0]        entry_year;
		logic               last_row;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] score;
		logic [4:0]         day;
		logic [3:0]         month;
		logic [11:0]        year;
	} entry_t;

endpackage

FILE: hw/rtl/tks_mem.sv
// Table memory: one write port, one read port with registered read data.
module tks_mem #(
	parameter int DEPTH = 10,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  tks_pkg::entry_t  wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output tks_pkg::entry_t  rd_data
);
	import tks_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold the last read word while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/top_k_score_table.sv
// Top level of the top-k score table: insert sequencer, table memory and output register.
//
//  channel | direction | payload               | handshake
//  --------+-----------+-----------------------+----------------------
//  in      | input     | tks_pkg::in_item_t    | in_valid / in_ready
//  out     | output    | tks_pkg::out_item_t   | out_valid / out_ready
//
// After a request is accepted, the sequencer steps through the table one row at a time,
// writing out entry_count rows, plus one more when the table is not yet full, so at
// most TABLE_DEPTH rows per request. The single memory read port sets this pace.
// Reset clears the row count and the sequencer; the memory is not cleared.
// A stalled output holds the sequencer; in_ready is low until the dump ends.
`include "top_k_score_table_defines.svh"

module top_k_score_table #(
	parameter int TABLE_DEPTH = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tks_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tks_pkg::out_item_t  out_data
);
	import tks_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = CW + 1;

	// sequencer state
	logic          busy_q;
	logic          placed_q;
	logic [CW-1:0] cur_q;
	logic [CW-1:0] count_q;
	entry_t        carry_q;

	// output register
	logic          out_valid_q;
	out_item_t     out_q;

	// memory interface
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	logic          accept;
	logic          step;
	logic          at_append;
	logic          table_full;
	logic          less;
	logic          shift;
	logic          last;
	logic [CW-1:0] next_idx;
	entry_t        row_entry;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;

	// advance one row whenever the output slot is free or being emptied
	assign step = busy_q && (!out_valid_q || out_ready);

	assign table_full = (count_q == CW'(TABLE_DEPTH));
	assign at_append  = (cur_q == count_q);
	assign next_idx   = cur_q + CW'(1);

	// the pending entry goes ahead of the first row with a strictly lower score;
	// once placed, every later row shifts down by one
	assign less      = $signed(mem_rdata.score) < $signed(carry_q.score);
	assign shift     = at_append || placed_q || less;
	assign row_entry = shift ? carry_q : mem_rdata;

	// a full table ends on its last row and drops the carried entry
	assign last = at_append || (table_full && (cur_q == CW'(TABLE_DEPTH - 1)));

	assign mem_we    = step && shift;
	assign mem_waddr = cur_q[AW-1:0];
	assign mem_wdata = row_entry;

	// fetch row 0 on a new request, otherwise the next row ahead of the step;
	// the write goes to the current row, so the two never collide
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		if (accept) begin
			mem_re    = (count_q != '0);
			mem_raddr = '0;
		end else if (step && !last) begin
			mem_re    = (next_idx < count_q);
			mem_raddr = next_idx[AW-1:0];
		end
	end

	tks_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			placed_q <= 1'b0;
			cur_q    <= '0;
			count_q  <= '0;
		end else if (accept) begin
			busy_q   <= 1'b1;
			placed_q <= 1'b0;
			cur_q    <= '0;
		end else if (step) begin
			placed_q <= placed_q || less;
			cur_q    <= next_idx;
			if (last) begin
				busy_q <= 1'b0;
				if (at_append) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	// carry the new entry, then each displaced row
	always_ff @(posedge clk) begin
		if (accept) begin
			carry_q.score <= in_data.new_score;
			carry_q.day   <= in_data.play_day;
			carry_q.month <= in_data.play_month;
			carry_q.year  <= in_data.play_year;
		end else if (step && shift) begin
			carry_q <= mem_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q.rank        <= 4'({1'b0, cur_q} + RW'(1));
			out_q.entry_score <= row_entry.score;
			out_q.entry_day   <= row_entry.day;
			out_q.entry_month <= row_entry.month;
			out_q.entry_year  <= row_entry.year;
			out_q.last_row    <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`TKS_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(TABLE_DEPTH))
	`TKS_ASSERT_IMP(a_cur_bound, clk, arst_n, busy_q, cur_q <= count_q)
	`TKS_ASSERT_IMP(a_write_on_step, clk, arst_n, mem_we, step && busy_q)
	`TKS_ASSERT_NXT(a_last_ends, clk, arst_n, step && last, !busy_q && out_valid && out_data.last_row)

endmodule
